// ----- hw/rtl/pkwrl_pkg.sv -----
// Shared types and constants for the per-key window rate limiter.
`timescale 1ns / 1ps
package pkwrl_pkg;

  localparam int KeyCountDef = 256;
  localparam int TimeBitsDef = 32;

  localparam int KeyW     = 8;
  localparam int NowW     = 32;
  localparam int CountW   = 16;
  localparam int WindowW  = 32;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  localparam logic CmdCheck = 1'b0;
  localparam logic CmdClear = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgMaxRequests = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWindowTicks = 2'd1;

  localparam logic [CountW-1:0]  MaxRequestsRst = 16'd100;
  localparam logic [WindowW-1:0] WindowTicksRst = 32'd60;

  typedef enum logic {
    StClear,
    StRun
  } ctl_state_e;

  typedef struct packed {
    logic            cmd;
    logic [KeyW-1:0] key_index;
    logic [NowW-1:0] now_ticks;
  } in_word_t;

  typedef struct packed {
    logic              allowed;
    logic [CountW-1:0] count_after;
  } out_word_t;

endpackage

// ----- hw/rtl/pkwrl_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module pkwrl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/pkwrl_update.sv -----
// Entry update datapath: window restart, admission test and new entry value.
`timescale 1ns / 1ps
module pkwrl_update #(
  parameter int TimeBits = pkwrl_pkg::TimeBitsDef
) (
  input  logic                                 cmd_i,
  input  logic                                 in_range_i,
  input  logic [TimeBits-1:0]                  now_i,
  input  logic [TimeBits+pkwrl_pkg::CountW-1:0] entry_i,
  input  logic [pkwrl_pkg::CountW-1:0]         max_requests_i,
  input  logic [pkwrl_pkg::WindowW-1:0]        window_ticks_i,
  output logic [TimeBits+pkwrl_pkg::CountW-1:0] entry_o,
  output pkwrl_pkg::out_word_t                 word_o
);

  localparam int CmpW = (TimeBits > pkwrl_pkg::WindowW) ? TimeBits : pkwrl_pkg::WindowW;

  logic [TimeBits-1:0]          start;
  logic [pkwrl_pkg::CountW-1:0] count;
  logic [TimeBits-1:0]          elapsed;
  logic                         restart;
  logic [TimeBits-1:0]          start_new;
  logic [pkwrl_pkg::CountW-1:0] count_base;
  logic                         ok;
  logic [pkwrl_pkg::CountW-1:0] count_new;

  always_comb begin
    start      = entry_i[TimeBits+pkwrl_pkg::CountW-1:pkwrl_pkg::CountW];
    count      = entry_i[pkwrl_pkg::CountW-1:0];
    elapsed    = now_i - start;
    restart    = CmpW'(elapsed) > CmpW'(window_ticks_i);
    start_new  = restart ? now_i : start;
    count_base = restart ? '0 : count;
    ok         = count_base < max_requests_i;
    count_new  = ok ? count_base + pkwrl_pkg::CountW'(1) : count_base;

    entry_o             = {start_new, count_new};
    word_o.allowed      = 1'b0;
    word_o.count_after  = '0;
    if (cmd_i == pkwrl_pkg::CmdClear) begin
      entry_o = '0;
    end else if (in_range_i) begin
      word_o.allowed     = ok;
      word_o.count_after = count_new;
    end
  end

endmodule

// ----- hw/rtl/per_key_window_rate_limiter_unit.sv -----
// Top level of the per-key window rate limiter.
// Pipeline: a word waits in the s1 registers, and its result is registered in out_word_q.
// Throughput: one word per cycle unless out_ready_i stalls; a read in the accept cycle,
//   read-modify-write as s1 fires; a just-written entry is forwarded to a same-key word.
// Reset: after rst_ni releases, a clearing pass writes zero to all KEY_COUNT entries, one a
//   cycle, and no word is accepted until it ends; config writes are taken throughout.
`timescale 1ns / 1ps
module per_key_window_rate_limiter_unit #(
  parameter int KEY_COUNT = pkwrl_pkg::KeyCountDef,
  parameter int TIME_BITS = pkwrl_pkg::TimeBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  pkwrl_pkg::in_word_t              in_word_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output pkwrl_pkg::out_word_t             out_word_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pkwrl_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pkwrl_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int AddrW  = $clog2(KEY_COUNT);
  localparam int EntryW = TIME_BITS + pkwrl_pkg::CountW;

  pkwrl_pkg::ctl_state_e state_q, state_d;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;
  logic             clearing;
  logic             clr_last;

  logic [pkwrl_pkg::CountW-1:0]  max_requests_q;
  logic [pkwrl_pkg::WindowW-1:0] window_ticks_q;

  logic                 s1_valid_q;
  logic                 s1_cmd_q;
  logic                 s1_in_range_q;
  logic [AddrW-1:0]     s1_addr_q;
  logic [TIME_BITS-1:0] s1_now_q;
  logic                 fwd_q;
  logic [EntryW-1:0]    fwd_data_q;

  logic                 out_valid_q;
  pkwrl_pkg::out_word_t out_word_q;

  logic                 in_acc;
  logic                 s1_fire;
  logic [AddrW-1:0]     in_addr;
  logic                 in_range;
  logic                 upd_we;
  logic                 ram_we;
  logic [AddrW-1:0]     ram_waddr;
  logic [EntryW-1:0]    ram_wdata;
  logic [EntryW-1:0]    ram_rdata;
  logic [EntryW-1:0]    entry_cur;
  logic [EntryW-1:0]    entry_new;
  pkwrl_pkg::out_word_t upd_word;

  // clearing pass sequencer
  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    case (state_q)
      pkwrl_pkg::StClear: begin
        clr_addr_d = clr_addr_q + AddrW'(1);
        if (clr_last) begin
          state_d = pkwrl_pkg::StRun;
        end
      end
      pkwrl_pkg::StRun: begin
        clr_addr_d = clr_addr_q;
      end
      default: begin
        state_d = pkwrl_pkg::StClear;
      end
    endcase
  end

  always_comb begin
    case (state_q)
      pkwrl_pkg::StClear: clearing = 1'b1;
      pkwrl_pkg::StRun:   clearing = 1'b0;
      default:            clearing = 1'b1;
    endcase
  end

  assign clr_last = clr_addr_q == AddrW'(KEY_COUNT - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pkwrl_pkg::StClear;
      clr_addr_q <= '0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_requests_q <= pkwrl_pkg::MaxRequestsRst;
      window_ticks_q <= pkwrl_pkg::WindowTicksRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == pkwrl_pkg::CfgMaxRequests) begin
        max_requests_q <= cfg_data_i[pkwrl_pkg::CountW-1:0];
      end
      if (cfg_index_i == pkwrl_pkg::CfgWindowTicks) begin
        window_ticks_q <= cfg_data_i[pkwrl_pkg::WindowW-1:0];
      end
    end
  end

  // handshake and pipeline control
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clearing && (!s1_valid_q || s1_fire);
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_addr    = AddrW'(in_word_i.key_index);
  assign in_range   = 32'(in_word_i.key_index) < 32'(KEY_COUNT);

  assign upd_we    = s1_fire && s1_in_range_q;
  assign ram_we    = clearing || upd_we;
  assign ram_waddr = clearing ? clr_addr_q : s1_addr_q;
  assign ram_wdata = clearing ? '0 : entry_new;
  assign entry_cur = fwd_q ? fwd_data_q : ram_rdata;

  pkwrl_ram #(
    .Width (EntryW),
    .Depth (KEY_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  pkwrl_update #(
    .TimeBits (TIME_BITS)
  ) u_update (
    .cmd_i          (s1_cmd_q),
    .in_range_i     (s1_in_range_q),
    .now_i          (s1_now_q),
    .entry_i        (entry_cur),
    .max_requests_i (max_requests_q),
    .window_ticks_i (window_ticks_q),
    .entry_o        (entry_new),
    .word_o         (upd_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= upd_we && (in_addr == s1_addr_q);
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q      <= in_word_i.cmd;
      s1_in_range_q <= in_range;
      s1_addr_q     <= in_addr;
      s1_now_q      <= TIME_BITS'(in_word_i.now_ticks);
      fwd_data_q    <= entry_new;
    end
    if (s1_fire) begin
      out_word_q <= upd_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ----- hw/rtl/pkwrl_checker.sv -----
// Port-level checks for the rate limiter, bound to the top level.
`timescale 1ns / 1ps
module pkwrl_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input pkwrl_pkg::out_word_t           out_word_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i))
    else $error("result word changed while stalled");

  a_allowed_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_word_i.allowed |-> out_word_i.count_after != '0)
    else $error("admitted request with zero count");

  a_rose_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result word without an accepted word two cycles earlier");

  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_i)
    else $error("word accepted before the table clear finished");

endmodule

bind per_key_window_rate_limiter_unit pkwrl_checker u_pkwrl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_i  (out_word_o)
);
